>>> design/cbq_pkg.sv
// Shared types and constants for the cascaded biquad voice band filter.
`default_nettype none

package cbq_pkg;

  // Field and datapath widths
  localparam int COEF_W  = 16;                // Q2.14 coefficient registers
  localparam int SMP_W   = 16;                // centered and filtered samples
  localparam int STATE_W = 32;                // filter state words
  localparam int DIG_W   = 4;                 // coefficient digit per cycle
  localparam int NDIG    = COEF_W / DIG_W;    // digits per product
  localparam int DIG_CW  = $clog2(NDIG);
  localparam int OP_W    = STATE_W + 1;       // operand: state word or difference of two
  localparam int PROD_W  = OP_W + DIG_W + 1;  // operand times one signed digit
  localparam int P_W     = OP_W + COEF_W;     // full product
  localparam int ACC_W   = 52;                // sum of up to five full products

  // APB register map
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IW  = 3;

  localparam logic [REG_IW-1:0] REG_HP_B0 = 3'd0;
  localparam logic [REG_IW-1:0] REG_HP_B1 = 3'd1;
  localparam logic [REG_IW-1:0] REG_HP_B2 = 3'd2;
  localparam logic [REG_IW-1:0] REG_HP_A1 = 3'd3;
  localparam logic [REG_IW-1:0] REG_HP_A2 = 3'd4;
  localparam logic [REG_IW-1:0] REG_BP_B0 = 3'd5;
  localparam logic [REG_IW-1:0] REG_BP_A1 = 3'd6;
  localparam logic [REG_IW-1:0] REG_BP_A2 = 3'd7;

  localparam logic signed [COEF_W-1:0] RST_HP_B0 = 16'sd15935;
  localparam logic signed [COEF_W-1:0] RST_HP_B1 = -16'sd31870;
  localparam logic signed [COEF_W-1:0] RST_HP_B2 = 16'sd15935;
  localparam logic signed [COEF_W-1:0] RST_HP_A1 = -16'sd31859;
  localparam logic signed [COEF_W-1:0] RST_HP_A2 = 16'sd15499;
  localparam logic signed [COEF_W-1:0] RST_BP_B0 = 16'sd6729;
  localparam logic signed [COEF_W-1:0] RST_BP_A1 = -16'sd17595;
  localparam logic signed [COEF_W-1:0] RST_BP_A2 = 16'sd2926;

  // One product of the sequence, in issue order
  typedef enum logic [2:0] {
    STEP_HP_B0,
    STEP_HP_B1,
    STEP_HP_B2,
    STEP_HP_A1,
    STEP_HP_A2,
    STEP_BP_B0,
    STEP_BP_A1,
    STEP_BP_A2
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIGIT,
    ST_HP_DONE,
    ST_BP_DONE,
    ST_OUT
  } state_t;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic load;   // start a product, fold the previous one into the sum
    logic clear;  // with load: start a fresh sum instead
    logic shift;  // consume one coefficient digit
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> design/cbq_if.sv
// Valid/ready channel interfaces for converter codes and filter results.
`default_nettype none

interface cbq_adc_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface cbq_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] centered_sample;
  logic signed [15:0] filtered_sample;

  modport source (output valid, output centered_sample, output filtered_sample, input ready);
  modport sink   (input valid, input centered_sample, input filtered_sample, output ready);
endinterface

`default_nettype wire

>>> design/cbq_mac.sv
// Digit-serial multiply-accumulate unit: 4 coefficient bits per cycle while shift is asserted, MSB digit first.
`default_nettype none

module cbq_mac (
  input  wire                             clk,
  input  cbq_pkg::mac_ctl_t               ctl,
  input  wire signed [cbq_pkg::OP_W-1:0]  opnd_in,
  input  wire signed [cbq_pkg::COEF_W-1:0] coef_in,
  input  wire                             sub_in,
  output logic signed [cbq_pkg::ACC_W-1:0] sum
);
  import cbq_pkg::*;

  logic signed [OP_W-1:0]   opnd;
  logic [COEF_W-1:0]        coef_sr;
  logic                     msd;      // top digit pending, carries the sign
  logic                     psub;
  logic signed [P_W-1:0]    p;
  logic signed [ACC_W-1:0]  acc;

  logic signed [DIG_W:0]    dig;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    dig  = msd ? $signed({coef_sr[COEF_W-1], coef_sr[COEF_W-1 -: DIG_W]})
               : $signed({1'b0, coef_sr[COEF_W-1 -: DIG_W]});
    prod = PROD_W'(opnd) * PROD_W'(dig);
    sum  = psub ? acc - ACC_W'(p) : acc + ACC_W'(p);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opnd    <= opnd_in;
      coef_sr <= coef_in;
      msd     <= 1'b1;
      psub    <= sub_in;
      p       <= '0;
      acc     <= ctl.clear ? '0 : sum;
    end else if (ctl.shift) begin
      p       <= (p <<< DIG_W) + P_W'(prod);
      coef_sr <= coef_sr << DIG_W;
      msd     <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> design/cascaded_biquad_voice_band_filter.sv
// Top level: centering plus two cascaded direct-form-I biquads on a shared digit-serial MAC.
//
//   port      | dir  | beat / access
//   ----------+------+-------------------------------------------------------------
//   adc       | sink | adc_code: one converter code per beat
//   filt      | src  | centered_sample, filtered_sample: one result beat per code
//   APB       | in   | 8 coefficient registers, 16-bit signed, at byte address 4*i
//
// Per beat: accept, high-pass products, high-pass saturation step, band-pass products,
// band-pass saturation step, output step; each of the 8 products is a load step plus
// the digit steps of the one 33x5-bit digit multiplier. One beat is in the datapath
// at a time. Reset (rst, synchronous) restores the coefficient reset values and
// zeroes the delay lines. A held result stalls only the output cycle; the next code
// is taken while the finished result still sits in the output register.
`default_nettype none

module cascaded_biquad_voice_band_filter #(
  parameter int ADC_BITS        = 12,
  parameter int COEF_FRAC_BITS  = 14,
  parameter int STATE_FRAC_BITS = 8
) (
  input  wire                            clk,
  input  wire                            rst,
  cbq_adc_if.sink                        adc,
  cbq_res_if.source                      filt,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [cbq_pkg::PADDR_W-1:0]     paddr,
  input  wire [cbq_pkg::PDATA_W-1:0]     pwdata,
  output logic [cbq_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import cbq_pkg::*;

  localparam logic [ADC_BITS:0] ADC_MID = (ADC_BITS + 1)'(1 << (ADC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);
  localparam logic signed [OP_W-1:0] TRUNC_BIAS =
    OP_W'((34'd1 << STATE_FRAC_BITS) - 34'd1);

  // ---------------------------------------------------------------- registers
  logic signed [COEF_W-1:0] hp_b0, hp_b1, hp_b2, hp_a1, hp_a2, bp_b0, bp_a1, bp_a2;

  logic signed [SMP_W-1:0]   hp_in_delay  [2];
  logic signed [STATE_W-1:0] hp_out_delay [2];
  logic signed [STATE_W-1:0] bp_in_delay  [2];
  logic signed [STATE_W-1:0] bp_out_delay [2];

  logic signed [SMP_W-1:0]   x;     // centered sample of the beat at work
  logic signed [STATE_W-1:0] hp;    // high-pass output of this beat
  logic signed [STATE_W-1:0] bp;    // band-pass output of this beat

  state_t             state, state_next;
  step_t              step, step_next;
  logic [DIG_CW-1:0]  dig, dig_next;

  logic               out_valid;
  logic signed [SMP_W-1:0] out_centered, out_filtered;

  // ---------------------------------------------------------------- config
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_b0 <= RST_HP_B0;
      hp_b1 <= RST_HP_B1;
      hp_b2 <= RST_HP_B2;
      hp_a1 <= RST_HP_A1;
      hp_a2 <= RST_HP_A2;
      bp_b0 <= RST_BP_B0;
      bp_a1 <= RST_BP_A1;
      bp_a2 <= RST_BP_A2;
    end else if (cfg_wr) begin
      unique case (paddr[PADDR_W-1:2])
        REG_HP_B0: hp_b0 <= pwdata[COEF_W-1:0];
        REG_HP_B1: hp_b1 <= pwdata[COEF_W-1:0];
        REG_HP_B2: hp_b2 <= pwdata[COEF_W-1:0];
        REG_HP_A1: hp_a1 <= pwdata[COEF_W-1:0];
        REG_HP_A2: hp_a2 <= pwdata[COEF_W-1:0];
        REG_BP_B0: bp_b0 <= pwdata[COEF_W-1:0];
        REG_BP_A1: bp_a1 <= pwdata[COEF_W-1:0];
        REG_BP_A2: bp_a2 <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_HP_B0: prdata = PDATA_W'(hp_b0);
      REG_HP_B1: prdata = PDATA_W'(hp_b1);
      REG_HP_B2: prdata = PDATA_W'(hp_b2);
      REG_HP_A1: prdata = PDATA_W'(hp_a1);
      REG_HP_A2: prdata = PDATA_W'(hp_a2);
      REG_BP_B0: prdata = PDATA_W'(bp_b0);
      REG_BP_A1: prdata = PDATA_W'(bp_a1);
      REG_BP_A2: prdata = PDATA_W'(bp_a2);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- centering
  // (mid - code) << (16 - ADC_BITS); only code 0 overflows, clamp it to +max.
  logic signed [ADC_BITS:0] cdiff;
  logic signed [SMP_W:0]    cwide;
  logic signed [SMP_W-1:0]  centered;

  always_comb begin
    cdiff    = $signed(ADC_MID - {1'b0, adc.adc_code});
    cwide    = (SMP_W + 1)'(cdiff) <<< (SMP_W - ADC_BITS);
    centered = (cwide > 17'sd32767) ? 16'sh7FFF : cwide[SMP_W-1:0];
  end

  // ---------------------------------------------------------------- operand select
  // b terms of the high-pass carry the state scale on the operand side.
  logic signed [OP_W-1:0]   opnd_sel;
  logic signed [COEF_W-1:0] coef_sel;
  logic                     sub_sel;

  always_comb begin
    unique case (step)
      STEP_HP_B0: opnd_sel = OP_W'(x) <<< STATE_FRAC_BITS;
      STEP_HP_B1: opnd_sel = OP_W'(hp_in_delay[0]) <<< STATE_FRAC_BITS;
      STEP_HP_B2: opnd_sel = OP_W'(hp_in_delay[1]) <<< STATE_FRAC_BITS;
      STEP_HP_A1: opnd_sel = OP_W'(hp_out_delay[0]);
      STEP_HP_A2: opnd_sel = OP_W'(hp_out_delay[1]);
      STEP_BP_B0: opnd_sel = OP_W'(hp) - OP_W'(bp_in_delay[1]);  // b2 = -b0, b1 = 0
      STEP_BP_A1: opnd_sel = OP_W'(bp_out_delay[0]);
      STEP_BP_A2: opnd_sel = OP_W'(bp_out_delay[1]);
      default:    opnd_sel = '0;
    endcase
    unique case (step)
      STEP_HP_B0: coef_sel = hp_b0;
      STEP_HP_B1: coef_sel = hp_b1;
      STEP_HP_B2: coef_sel = hp_b2;
      STEP_HP_A1: coef_sel = hp_a1;
      STEP_HP_A2: coef_sel = hp_a2;
      STEP_BP_B0: coef_sel = bp_b0;
      STEP_BP_A1: coef_sel = bp_a1;
      STEP_BP_A2: coef_sel = bp_a2;
      default:    coef_sel = '0;
    endcase
    sub_sel = (step == STEP_HP_A1) || (step == STEP_HP_A2) ||
              (step == STEP_BP_A1) || (step == STEP_BP_A2);
  end

  // ---------------------------------------------------------------- MAC
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] mac_sum;

  cbq_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .opnd_in (opnd_sel),
    .coef_in (coef_sel),
    .sub_in  (sub_sel),
    .sum     (mac_sum)
  );

  // floor shift, then clamp to the state word
  logic signed [ACC_W-1:0]   acc_shr;
  logic signed [STATE_W-1:0] acc_sat;

  always_comb begin
    acc_shr = mac_sum >>> COEF_FRAC_BITS;
    if (acc_shr > SAT_HI) begin
      acc_sat = STATE_W'(SAT_HI);
    end else if (acc_shr < SAT_LO) begin
      acc_sat = STATE_W'(SAT_LO);
    end else begin
      acc_sat = acc_shr[STATE_W-1:0];
    end
  end

  // band-pass word to integer sample: round toward zero, clamp to 16 bits
  logic signed [OP_W-1:0]  bp_biased;
  logic signed [OP_W-1:0]  bp_int;
  logic signed [SMP_W-1:0] filtered;

  always_comb begin
    bp_biased = OP_W'(bp) + (bp[STATE_W-1] ? TRUNC_BIAS : '0);
    bp_int    = bp_biased >>> STATE_FRAC_BITS;
    if (bp_int > 33'sd32767) begin
      filtered = 16'sh7FFF;
    end else if (bp_int < -33'sd32768) begin
      filtered = 16'sh8000;
    end else begin
      filtered = bp_int[SMP_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic in_take, ld_hp, ld_bp, ld_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_HP_B0;
      dig   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      dig   <= dig_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    dig_next   = dig;
    mac_ctl    = '0;
    in_take    = 1'b0;
    ld_hp      = 1'b0;
    ld_bp      = 1'b0;
    ld_out     = 1'b0;
    adc.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        adc.ready = 1'b1;
        if (adc.valid) begin
          in_take    = 1'b1;
          step_next  = STEP_HP_B0;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mac_ctl.load  = 1'b1;
        mac_ctl.clear = (step == STEP_HP_B0) || (step == STEP_BP_B0);
        dig_next      = '0;
        state_next    = ST_DIGIT;
      end
      ST_DIGIT: begin
        mac_ctl.shift = 1'b1;
        dig_next      = dig + 1'b1;
        if (dig == DIG_CW'(NDIG - 1)) begin
          priority if (step == STEP_HP_A2) begin
            state_next = ST_HP_DONE;
          end else if (step == STEP_BP_A2) begin
            state_next = ST_BP_DONE;
          end else begin
            step_next  = step_t'(step + 3'd1);
            state_next = ST_LOAD;
          end
        end
      end
      ST_HP_DONE: begin
        ld_hp      = 1'b1;
        step_next  = STEP_BP_B0;
        state_next = ST_LOAD;
      end
      ST_BP_DONE: begin
        ld_bp      = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || filt.ready) begin
          ld_out     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      x <= centered;
    end
    if (ld_hp) begin
      hp <= acc_sat;
    end
    if (ld_bp) begin
      bp <= acc_sat;
    end
    if (ld_out) begin
      out_centered <= x;
      out_filtered <= filtered;
    end
  end

  // delay lines advance once per beat, after the last product read them
  always_ff @(posedge clk) begin
    if (rst) begin
      hp_in_delay  <= '{default: '0};
      hp_out_delay <= '{default: '0};
      bp_in_delay  <= '{default: '0};
      bp_out_delay <= '{default: '0};
    end else if (ld_bp) begin
      hp_in_delay[1]  <= hp_in_delay[0];
      hp_in_delay[0]  <= x;
      hp_out_delay[1] <= hp_out_delay[0];
      hp_out_delay[0] <= hp;
      bp_in_delay[1]  <= bp_in_delay[0];
      bp_in_delay[0]  <= hp;
      bp_out_delay[1] <= bp_out_delay[0];
      bp_out_delay[0] <= acc_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (filt.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign filt.valid           = out_valid;
  assign filt.centered_sample = out_centered;
  assign filt.filtered_sample = out_filtered;

endmodule

`default_nettype wire
